### rtl/core/hanja_hangul_code_converter_assert.svh
// assertion macros shared by the converter rtl
// depends on nothing; included by modules that carry concurrent checks
`ifndef HANJA_HANGUL_CODE_CONVERTER_ASSERT_SVH
`define HANJA_HANGUL_CODE_CONVERTER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define HHCC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("hhcc assertion failed");

// next-cycle implication, checked outside reset
`define HHCC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("hhcc assertion failed");

`endif

### rtl/core/hhcc_pkg.sv
// shared types and constants of the hanja to hangul code converter
// no dependencies; used by every other rtl file except the table ram and the assertion header
package hhcc_pkg;

    // table geometry
    localparam int TABLE_DEPTH  = 512;
    localparam int ADDR_W       = $clog2(TABLE_DEPTH);
    localparam int MAX_READINGS = 63;

    // field widths
    localparam int CMD_W    = 2;
    localparam int INDEX_W  = 9;
    localparam int HANGUL_W = 16;
    localparam int COUNT_W  = 6;
    localparam int OFFSET_W = 13;
    localparam int BYTE_W   = 8;
    localparam int KIND_W   = 2;
    localparam int CFG_W    = 10;

    // commands
    localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CONVERT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LIST    = 2'd2;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_CODE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CAND  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd2;

    // hanja code space
    localparam logic [BYTE_W-1:0] LEAD_MIN   = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD_MAX   = 8'hFA;
    localparam logic [BYTE_W-1:0] TRAIL1_MIN = 8'h31;
    localparam logic [BYTE_W-1:0] TRAIL1_MAX = 8'h7E;
    localparam logic [BYTE_W-1:0] TRAIL2_MIN = 8'h91;
    localparam logic [BYTE_W-1:0] TRAIL2_MAX = 8'hFE;
    localparam logic [BYTE_W-1:0] TRAIL_GAP  = 8'h12;
    localparam int                ROW_SPAN   = 188;
    localparam int                LOW_BAND   = 78;

    localparam logic [CFG_W-1:0] ENTRIES_RESET = 10'd473;

    // one table entry as stored in memory
    typedef struct packed {
        logic [HANGUL_W-1:0] hangul;
        logic [COUNT_W-1:0]  count;
        logic [OFFSET_W-1:0] offset;
    } t_entry;

    // decoded view of the queried two-byte code
    typedef struct packed {
        logic                in_range;
        logic [OFFSET_W-1:0] offset;
        logic [HANGUL_W-1:0] key;
    } t_query;

endpackage

### rtl/core/hhcc_chan_if.sv
// request and response channel interfaces of the converter
// depends on hhcc_pkg for field widths
interface hhcc_req_if;
    logic                                valid;
    logic                                ready;
    logic [hhcc_pkg::CMD_W-1:0]          cmd;
    logic [hhcc_pkg::INDEX_W-1:0]        entry_index;
    logic [hhcc_pkg::HANGUL_W-1:0]       entry_hangul;
    logic [hhcc_pkg::COUNT_W-1:0]        entry_count;
    logic [hhcc_pkg::OFFSET_W-1:0]       entry_offset;
    logic [hhcc_pkg::BYTE_W-1:0]         code_high;
    logic [hhcc_pkg::BYTE_W-1:0]         code_low;

    modport source (
        output valid, cmd, entry_index, entry_hangul, entry_count, entry_offset,
               code_high, code_low,
        input  ready
    );
    modport sink (
        input  valid, cmd, entry_index, entry_hangul, entry_count, entry_offset,
               code_high, code_low,
        output ready
    );
endinterface

interface hhcc_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [hhcc_pkg::KIND_W-1:0]   result_kind;
    logic [hhcc_pkg::BYTE_W-1:0]   out_high;
    logic [hhcc_pkg::BYTE_W-1:0]   out_low;
    logic                          passed_through;
    logic                          last;

    modport source (
        output valid, result_kind, out_high, out_low, passed_through, last,
        input  ready
    );
    modport sink (
        input  valid, result_kind, out_high, out_low, passed_through, last,
        output ready
    );
endinterface

### rtl/core/hhcc_table_ram.sv
// generic single-port-write, single-port-read synchronous ram
// no dependencies; read data registered
module hhcc_table_ram #(
    parameter int DEPTH = 512,
    parameter int WIDTH = 35
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

### rtl/core/hhcc_query_decode.sv
// range check and linear offset of the queried two-byte code
// depends on hhcc_pkg; pure combinational
module hhcc_query_decode (
    input  logic [hhcc_pkg::BYTE_W-1:0] i_code_high,
    input  logic [hhcc_pkg::BYTE_W-1:0] i_code_low,
    output hhcc_pkg::t_query            o_query
);

    logic                              w_lead_ok;
    logic                              w_trail_ok;
    logic [hhcc_pkg::BYTE_W-1:0]       w_trail_adj;
    logic [4:0]                        w_row;
    logic [hhcc_pkg::OFFSET_W-1:0]     w_row_base;

    // hanja lead and trail windows
    always_comb begin
        w_lead_ok  = i_code_high inside {[hhcc_pkg::LEAD_MIN:hhcc_pkg::LEAD_MAX]};
        w_trail_ok = (i_code_low inside {[hhcc_pkg::TRAIL1_MIN:hhcc_pkg::TRAIL1_MAX]}) ||
                     (i_code_low inside {[hhcc_pkg::TRAIL2_MIN:hhcc_pkg::TRAIL2_MAX]});
    end

    // trail position inside a row, upper band closes the gap
    always_comb begin
        if (i_code_low >= hhcc_pkg::TRAIL2_MIN) begin
            w_trail_adj = i_code_low - hhcc_pkg::TRAIL_GAP - hhcc_pkg::TRAIL1_MIN;
        end else begin
            w_trail_adj = i_code_low - hhcc_pkg::TRAIL1_MIN;
        end
    end

    // row times row span plus trail position
    always_comb begin
        w_row      = 5'(i_code_high - hhcc_pkg::LEAD_MIN);
        w_row_base = hhcc_pkg::OFFSET_W'(w_row) *
                     hhcc_pkg::OFFSET_W'(hhcc_pkg::ROW_SPAN);
        o_query.in_range = w_lead_ok && w_trail_ok;
        o_query.offset   = w_row_base + hhcc_pkg::OFFSET_W'(w_trail_adj);
        o_query.key      = {i_code_high, i_code_low};
    end

endmodule

### rtl/core/hhcc_scan_fsm.sv
// sequencer: table loads, sequential table scans, candidate generation
// depends on hhcc_pkg, hhcc_chan_if and the assertion macro header
module hhcc_scan_fsm (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [hhcc_pkg::CFG_W-1:0]      i_cfg_data,
    hhcc_req_if.sink                        i_req,
    hhcc_rsp_if.source                      o_rsp,
    input  hhcc_pkg::t_query                i_query,
    output logic [hhcc_pkg::BYTE_W-1:0]     o_code_high,
    output logic [hhcc_pkg::BYTE_W-1:0]     o_code_low,
    output logic                            o_ram_we,
    output logic [hhcc_pkg::ADDR_W-1:0]     o_ram_waddr,
    output hhcc_pkg::t_entry                o_ram_wdata,
    output logic [hhcc_pkg::ADDR_W-1:0]     o_ram_raddr,
    input  hhcc_pkg::t_entry                i_ram_rdata
);

`include "hanja_hangul_code_converter_assert.svh"

    localparam logic [2:0] ST_IDLE       = 3'd0;
    localparam logic [2:0] ST_CONV_START = 3'd1;
    localparam logic [2:0] ST_CONV_SCAN  = 3'd2;
    localparam logic [2:0] ST_LIST_SCAN  = 3'd3;
    localparam logic [2:0] ST_DIV_EST    = 3'd4;
    localparam logic [2:0] ST_DIV_FIX    = 3'd5;
    localparam logic [2:0] ST_EMIT_CAND  = 3'd6;
    localparam logic [2:0] ST_EMIT_ONE   = 3'd7;

    // reciprocal of the row span, applied after dropping two low bits
    localparam int DIV_PRE_SHIFT = 2;
    localparam int RECIP_MUL     = 1394;
    localparam int RECIP_SHIFT   = 16;
    localparam int PROD_W        = 23;
    localparam int Q_W           = 6;
    localparam int REM_W         = 9;
    localparam int LIN_W         = 14;

    localparam logic [hhcc_pkg::BYTE_W-1:0] HIGH_BAND_BIAS =
        hhcc_pkg::TRAIL2_MIN - 8'(hhcc_pkg::LOW_BAND);

    // control state
    logic [2:0]                        r_state, n_state;
    logic [hhcc_pkg::CFG_W-1:0]        r_entries_used, n_entries_used;
    logic [hhcc_pkg::ADDR_W-1:0]       r_cur, n_cur;
    logic [hhcc_pkg::COUNT_W-1:0]      r_left, n_left;
    logic                              r_out_valid, n_out_valid;

    // payload state
    logic [hhcc_pkg::BYTE_W-1:0]       r_code_high, n_code_high;
    logic [hhcc_pkg::BYTE_W-1:0]       r_code_low, n_code_low;
    logic [hhcc_pkg::HANGUL_W-1:0]     r_prev_hangul, n_prev_hangul;
    logic [hhcc_pkg::KIND_W-1:0]       r_res_kind, n_res_kind;
    logic [hhcc_pkg::BYTE_W-1:0]       r_res_high, n_res_high;
    logic [hhcc_pkg::BYTE_W-1:0]       r_res_low, n_res_low;
    logic                              r_res_passed, n_res_passed;
    logic [hhcc_pkg::OFFSET_W-1:0]     r_lin, n_lin;
    logic [Q_W-1:0]                    r_q, n_q;
    logic [hhcc_pkg::BYTE_W-1:0]       r_hi, n_hi;
    logic [hhcc_pkg::BYTE_W-1:0]       r_rem, n_rem;
    logic [hhcc_pkg::KIND_W-1:0]       r_out_kind, n_out_kind;
    logic [hhcc_pkg::BYTE_W-1:0]       r_out_high, n_out_high;
    logic [hhcc_pkg::BYTE_W-1:0]       r_out_low, n_out_low;
    logic                              r_out_passed, n_out_passed;
    logic                              r_out_last, n_out_last;

    logic                              w_in_xfer;
    logic                              w_slot_free;
    logic                              w_scanning;
    logic [hhcc_pkg::ADDR_W-1:0]       w_last;
    logic [PROD_W-1:0]                 w_prod;
    logic [REM_W-1:0]                  w_rem_raw;
    logic [Q_W-1:0]                    w_q_fix;
    logic [REM_W-1:0]                  w_rem_fix;
    logic [hhcc_pkg::COUNT_W-1:0]      w_count_sat;

    // trail byte from position inside a row
    function automatic logic [hhcc_pkg::BYTE_W-1:0] trail_of(
        input logic [hhcc_pkg::BYTE_W-1:0] pos
    );
        if (pos < 8'(hhcc_pkg::LOW_BAND)) begin
            return pos + hhcc_pkg::TRAIL1_MIN;
        end else begin
            return pos + HIGH_BAND_BIAS;
        end
    endfunction

    // handshakes and table ports
    always_comb begin
        i_req.ready = (r_state == ST_IDLE);
        w_in_xfer   = i_req.valid && (r_state == ST_IDLE);
        w_slot_free = !r_out_valid || o_rsp.ready;
        w_scanning  = (r_state == ST_CONV_SCAN) || (r_state == ST_LIST_SCAN);
        o_ram_we    = w_in_xfer && (i_req.cmd == hhcc_pkg::CMD_LOAD) &&
                      (32'(i_req.entry_index) < 32'(hhcc_pkg::TABLE_DEPTH));
        o_ram_waddr = hhcc_pkg::ADDR_W'(i_req.entry_index);
        o_ram_wdata.hangul = i_req.entry_hangul;
        o_ram_wdata.count  = i_req.entry_count;
        o_ram_wdata.offset = i_req.entry_offset;
        o_ram_raddr = w_scanning ? hhcc_pkg::ADDR_W'(r_cur + 1'b1) : '0;
        o_code_high = r_code_high;
        o_code_low  = r_code_low;
    end

    // last searched entry from the entry count register
    always_comb begin
        if (r_entries_used == '0) begin
            w_last = '0;
        end else if (32'(r_entries_used) >= 32'(hhcc_pkg::TABLE_DEPTH)) begin
            w_last = hhcc_pkg::ADDR_W'(hhcc_pkg::TABLE_DEPTH - 1);
        end else begin
            w_last = hhcc_pkg::ADDR_W'(r_entries_used - 1'b1);
        end
    end

    // split of the first candidate offset into row and position
    always_comb begin
        w_prod    = PROD_W'(r_lin >> DIV_PRE_SHIFT) * PROD_W'(RECIP_MUL);
        w_rem_raw = REM_W'(LIN_W'(r_lin) - LIN_W'(r_q) * LIN_W'(hhcc_pkg::ROW_SPAN));
        if (w_rem_raw >= REM_W'(hhcc_pkg::ROW_SPAN)) begin
            w_q_fix   = r_q + 1'b1;
            w_rem_fix = w_rem_raw - REM_W'(hhcc_pkg::ROW_SPAN);
        end else begin
            w_q_fix   = r_q;
            w_rem_fix = w_rem_raw;
        end
        if (32'(i_ram_rdata.count) > 32'(hhcc_pkg::MAX_READINGS)) begin
            w_count_sat = hhcc_pkg::COUNT_W'(hhcc_pkg::MAX_READINGS);
        end else begin
            w_count_sat = i_ram_rdata.count;
        end
    end

    // next state
    always_comb begin
        n_state        = r_state;
        n_entries_used = r_entries_used;
        n_cur          = r_cur;
        n_left         = r_left;
        n_out_valid    = r_out_valid;
        n_code_high    = r_code_high;
        n_code_low     = r_code_low;
        n_prev_hangul  = r_prev_hangul;
        n_res_kind     = r_res_kind;
        n_res_high     = r_res_high;
        n_res_low      = r_res_low;
        n_res_passed   = r_res_passed;
        n_lin          = r_lin;
        n_q            = r_q;
        n_hi           = r_hi;
        n_rem          = r_rem;
        n_out_kind     = r_out_kind;
        n_out_high     = r_out_high;
        n_out_low      = r_out_low;
        n_out_passed   = r_out_passed;
        n_out_last     = r_out_last;

        if (i_cfg_we) begin
            n_entries_used = i_cfg_data;
        end
        if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (w_in_xfer) begin
                    n_code_high = i_req.code_high;
                    n_code_low  = i_req.code_low;
                    n_cur       = '0;
                    case (i_req.cmd)
                        hhcc_pkg::CMD_CONVERT: n_state = ST_CONV_SCAN;
                        hhcc_pkg::CMD_LIST:    n_state = ST_LIST_SCAN;
                        default:               n_state = ST_IDLE;
                    endcase
                end
            end
            ST_CONV_START: begin
                n_cur   = '0;
                n_state = ST_CONV_SCAN;
            end
            ST_CONV_SCAN: begin
                n_res_kind   = hhcc_pkg::KIND_CODE;
                n_res_passed = 1'b0;
                if (!i_query.in_range) begin
                    n_res_high   = r_code_high;
                    n_res_low    = r_code_low;
                    n_res_passed = 1'b1;
                    n_state      = ST_EMIT_ONE;
                end else if (i_ram_rdata.offset > i_query.offset) begin
                    // offset below entry 0 clamps to entry 0
                    if (r_cur == '0) begin
                        {n_res_high, n_res_low} = i_ram_rdata.hangul;
                    end else begin
                        {n_res_high, n_res_low} = r_prev_hangul;
                    end
                    n_state = ST_EMIT_ONE;
                end else if (r_cur == w_last) begin
                    {n_res_high, n_res_low} = i_ram_rdata.hangul;
                    n_state = ST_EMIT_ONE;
                end else begin
                    n_prev_hangul = i_ram_rdata.hangul;
                    n_cur         = r_cur + 1'b1;
                end
            end
            ST_LIST_SCAN: begin
                if (i_ram_rdata.hangul == i_query.key) begin
                    n_lin  = i_ram_rdata.offset;
                    n_left = w_count_sat;
                    if (w_count_sat == '0) begin
                        n_res_kind   = hhcc_pkg::KIND_EMPTY;
                        n_res_high   = '0;
                        n_res_low    = '0;
                        n_res_passed = 1'b0;
                        n_state      = ST_EMIT_ONE;
                    end else begin
                        n_state = ST_DIV_EST;
                    end
                end else if (r_cur == w_last) begin
                    // no matching hangul: convert the code instead
                    n_state = ST_CONV_START;
                end else begin
                    n_cur = r_cur + 1'b1;
                end
            end
            ST_DIV_EST: begin
                n_q     = Q_W'(w_prod >> RECIP_SHIFT);
                n_state = ST_DIV_FIX;
            end
            ST_DIV_FIX: begin
                n_hi    = hhcc_pkg::LEAD_MIN + hhcc_pkg::BYTE_W'(w_q_fix);
                n_rem   = hhcc_pkg::BYTE_W'(w_rem_fix);
                n_state = ST_EMIT_CAND;
            end
            ST_EMIT_CAND: begin
                if (w_slot_free) begin
                    n_out_valid  = 1'b1;
                    n_out_kind   = hhcc_pkg::KIND_CAND;
                    n_out_high   = r_hi;
                    n_out_low    = trail_of(r_rem);
                    n_out_passed = 1'b0;
                    n_out_last   = (r_left == hhcc_pkg::COUNT_W'(1));
                    n_left       = r_left - 1'b1;
                    if (r_rem == hhcc_pkg::BYTE_W'(hhcc_pkg::ROW_SPAN - 1)) begin
                        n_rem = '0;
                        n_hi  = r_hi + 1'b1;
                    end else begin
                        n_rem = r_rem + 1'b1;
                    end
                    if (r_left == hhcc_pkg::COUNT_W'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_EMIT_ONE: begin
                if (w_slot_free) begin
                    n_out_valid  = 1'b1;
                    n_out_kind   = r_res_kind;
                    n_out_high   = r_res_high;
                    n_out_low    = r_res_low;
                    n_out_passed = r_res_passed;
                    n_out_last   = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_entries_used <= hhcc_pkg::ENTRIES_RESET;
            r_cur          <= '0;
            r_left         <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_entries_used <= n_entries_used;
            r_cur          <= n_cur;
            r_left         <= n_left;
            r_out_valid    <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_code_high   <= n_code_high;
        r_code_low    <= n_code_low;
        r_prev_hangul <= n_prev_hangul;
        r_res_kind    <= n_res_kind;
        r_res_high    <= n_res_high;
        r_res_low     <= n_res_low;
        r_res_passed  <= n_res_passed;
        r_lin         <= n_lin;
        r_q           <= n_q;
        r_hi          <= n_hi;
        r_rem         <= n_rem;
        r_out_kind    <= n_out_kind;
        r_out_high    <= n_out_high;
        r_out_low     <= n_out_low;
        r_out_passed  <= n_out_passed;
        r_out_last    <= n_out_last;
    end

    // response port
    always_comb begin
        o_rsp.valid          = r_out_valid;
        o_rsp.result_kind    = r_out_kind;
        o_rsp.out_high       = r_out_high;
        o_rsp.out_low        = r_out_low;
        o_rsp.passed_through = r_out_passed;
        o_rsp.last           = r_out_last;
    end

    // checks
    `HHCC_ASSERT_IMP(a_scan_in_bounds, i_clk, i_rst_n, w_scanning, r_cur <= w_last)
    `HHCC_ASSERT_IMP(a_cand_left, i_clk, i_rst_n, r_state == ST_EMIT_CAND, r_left != '0)
    `HHCC_ASSERT_IMP(a_rem_bound, i_clk, i_rst_n, r_state == ST_DIV_FIX,
        w_rem_raw < REM_W'(2 * hhcc_pkg::ROW_SPAN))
    `HHCC_ASSERT_NXT(a_final_cand, i_clk, i_rst_n,
        (r_state == ST_EMIT_CAND) && w_slot_free && (r_left == hhcc_pkg::COUNT_W'(1)),
        (r_state == ST_IDLE) && r_out_valid && r_out_last)

endmodule

### rtl/core/hanja_hangul_code_converter.sv
// top level of the hanja to hangul code converter
// depends on hhcc_pkg, hhcc_chan_if, hhcc_query_decode, hhcc_scan_fsm, hhcc_table_ram
//
// Reading-table converter with one request and one response channel. A load
// transfer writes one table entry. Requests are worked on one at a time; the
// table has a single read port that returns one entry per cycle. A convert
// scans entries in order, at most entries_used of them (saturated to 1..table
// depth). A list scans for the matching hangul, splits its offset into row
// and position, then emits its candidates one by one as the output register
// frees; when no entry matches, a full scan is followed by a convert scan. A
// finished result sits in an output register, so the next request is taken
// while it waits. entries_used must only be written while the block is idle.
module hanja_hangul_code_converter (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [hhcc_pkg::CFG_W-1:0]  i_cfg_data,
    hhcc_req_if.sink                    i_req,
    hhcc_rsp_if.source                  o_rsp
);

    hhcc_pkg::t_query                   w_query;
    logic [hhcc_pkg::BYTE_W-1:0]        w_code_high;
    logic [hhcc_pkg::BYTE_W-1:0]        w_code_low;
    logic                               w_ram_we;
    logic [hhcc_pkg::ADDR_W-1:0]        w_ram_waddr;
    hhcc_pkg::t_entry                   w_ram_wdata;
    logic [hhcc_pkg::ADDR_W-1:0]        w_ram_raddr;
    hhcc_pkg::t_entry                   w_ram_rdata;

    // query decode
    hhcc_query_decode u_decode (
        .i_code_high (w_code_high),
        .i_code_low  (w_code_low),
        .o_query     (w_query)
    );

    // sequencer and output register
    hhcc_scan_fsm u_fsm (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_req       (i_req),
        .o_rsp       (o_rsp),
        .i_query     (w_query),
        .o_code_high (w_code_high),
        .o_code_low  (w_code_low),
        .o_ram_we    (w_ram_we),
        .o_ram_waddr (w_ram_waddr),
        .o_ram_wdata (w_ram_wdata),
        .o_ram_raddr (w_ram_raddr),
        .i_ram_rdata (w_ram_rdata)
    );

    // reading table
    hhcc_table_ram #(
        .DEPTH (hhcc_pkg::TABLE_DEPTH),
        .WIDTH ($bits(hhcc_pkg::t_entry))
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

endmodule
